/* sv/jts_pkg.sv */
// Shared types, codes and constants of the JSON token scanner.
`default_nettype none
package jts_pkg;

	// Scanner modes between bytes.
	typedef enum logic [2:0] {
		M_IDLE,
		M_STR,
		M_ESC,
		M_INT,
		M_FRAC,
		M_EXP0,
		M_EXPD,
		M_WORD
	} mode_t;

	// Token kinds as they appear on the result stream.
	typedef enum logic [3:0] {
		TK_LBRACE  = 4'd0,
		TK_RBRACE  = 4'd1,
		TK_LBRACK  = 4'd2,
		TK_RBRACK  = 4'd3,
		TK_COMMA   = 4'd4,
		TK_COLON   = 4'd5,
		TK_STRING  = 4'd6,
		TK_NUMBER  = 4'd7,
		TK_TRUE    = 4'd8,
		TK_FALSE   = 4'd9,
		TK_NULL    = 4'd10,
		TK_EOF     = 4'd11,
		TK_INVALID = 4'd12
	} tok_kind_t;

	// Keyword tracking codes: a code names the keyword prefix matched so far.
	localparam logic [3:0] KW_NONE   = 4'd0;
	localparam logic [3:0] KW_T      = 4'd1;
	localparam logic [3:0] KW_TR     = 4'd2;
	localparam logic [3:0] KW_TRU    = 4'd3;
	localparam logic [3:0] KW_TRUE   = 4'd4;
	localparam logic [3:0] KW_F      = 4'd5;
	localparam logic [3:0] KW_FA     = 4'd6;
	localparam logic [3:0] KW_FAL    = 4'd7;
	localparam logic [3:0] KW_FALS   = 4'd8;
	localparam logic [3:0] KW_FALSE  = 4'd9;
	localparam logic [3:0] KW_N      = 4'd10;
	localparam logic [3:0] KW_NU     = 4'd11;
	localparam logic [3:0] KW_NUL    = 4'd12;
	localparam logic [3:0] KW_NULL   = 4'd13;
	localparam logic [3:0] KW_FAIL   = 4'd15;

	// Characters the scanner recognizes.
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_UP_A   = 8'h41;
	localparam logic [7:0] CH_UP_E   = 8'h45;
	localparam logic [7:0] CH_UP_Z   = 8'h5A;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_LO_A   = 8'h61;
	localparam logic [7:0] CH_LO_E   = 8'h65;
	localparam logic [7:0] CH_LO_F   = 8'h66;
	localparam logic [7:0] CH_LO_L   = 8'h6C;
	localparam logic [7:0] CH_LO_N   = 8'h6E;
	localparam logic [7:0] CH_LO_R   = 8'h72;
	localparam logic [7:0] CH_LO_S   = 8'h73;
	localparam logic [7:0] CH_LO_T   = 8'h74;
	localparam logic [7:0] CH_LO_U   = 8'h75;
	localparam logic [7:0] CH_LO_Z   = 8'h7A;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	// One result item.
	typedef struct packed {
		logic        last;
		logic [31:0] length;
		logic [31:0] offset;
		logic [31:0] column;
		logic [31:0] line;
		tok_kind_t   kind;
	} token_t;

	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 136;

	// Result queue sizing: room for two items in flight of two tokens each.
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_PTR_W = 3;
	localparam int FIFO_CNT_W = 4;
	localparam logic [FIFO_CNT_W-1:0] ACCEPT_LIMIT = FIFO_CNT_W'(FIFO_DEPTH - 4);

	// Advance the keyword prefix match by one letter.
	function automatic logic [3:0] kw_next(input logic [3:0] code, input logic [7:0] b);
		logic [3:0] nx;
		begin
			nx = KW_FAIL;
			case (code)
				KW_T:    if (b == CH_LO_R) nx = KW_TR;
				KW_TR:   if (b == CH_LO_U) nx = KW_TRU;
				KW_TRU:  if (b == CH_LO_E) nx = KW_TRUE;
				KW_F:    if (b == CH_LO_A) nx = KW_FA;
				KW_FA:   if (b == CH_LO_L) nx = KW_FAL;
				KW_FAL:  if (b == CH_LO_S) nx = KW_FALS;
				KW_FALS: if (b == CH_LO_E) nx = KW_FALSE;
				KW_N:    if (b == CH_LO_U) nx = KW_NU;
				KW_NU:   if (b == CH_LO_L) nx = KW_NUL;
				KW_NUL:  if (b == CH_LO_L) nx = KW_NULL;
				default: nx = KW_FAIL;
			endcase
			return nx;
		end
	endfunction

endpackage
`default_nettype wire

/* sv/jts_token_fifo.sv */
// Result queue that takes up to two tokens a cycle and hands out one.
`default_nettype none
module jts_token_fifo (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic [1:0]                   push_cnt,
	input  wire jts_pkg::token_t              push0,
	input  wire jts_pkg::token_t              push1,
	input  wire logic                         pop,
	output jts_pkg::token_t                   head,
	output logic [jts_pkg::FIFO_CNT_W-1:0]    count
);
	import jts_pkg::*;

	token_t                 mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0]  wr_q;
	logic [FIFO_PTR_W-1:0]  rd_q;
	logic [FIFO_PTR_W-1:0]  wr_p1;
	logic [FIFO_CNT_W-1:0]  count_q;

	assign wr_p1 = wr_q + 1'b1;
	assign head  = mem_q[rd_q];
	assign count = count_q;

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) mem_q[wr_q] <= push0;
		if (push_cnt == 2'd2) mem_q[wr_p1] <= push1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + FIFO_PTR_W'(push_cnt);
			rd_q    <= rd_q + FIFO_PTR_W'(pop);
			count_q <= count_q + FIFO_CNT_W'(push_cnt) - FIFO_CNT_W'(pop);
		end
	end

endmodule
`default_nettype wire

/* sv/jts_lexer.sv */
// Next-state and token logic of the scanner for one byte.
`default_nettype none
module jts_lexer #(
	parameter int COUNTER_BITS = 32
) (
	input  wire logic [7:0]              text_byte,
	input  wire logic                    fin,
	input  wire jts_pkg::mode_t          mode_q,
	input  wire logic [3:0]              kw_q,
	input  wire logic [COUNTER_BITS-1:0] pos_q,
	input  wire logic [COUNTER_BITS-1:0] line_q,
	input  wire logic [COUNTER_BITS-1:0] col_q,
	input  wire logic [COUNTER_BITS-1:0] soff_q,
	input  wire logic [COUNTER_BITS-1:0] sline_q,
	input  wire logic [COUNTER_BITS-1:0] scol_q,
	output jts_pkg::mode_t               mode_n,
	output logic [3:0]                   kw_n,
	output logic [COUNTER_BITS-1:0]      pos_n,
	output logic [COUNTER_BITS-1:0]      line_n,
	output logic [COUNTER_BITS-1:0]      col_n,
	output logic [COUNTER_BITS-1:0]      soff_n,
	output logic [COUNTER_BITS-1:0]      sline_n,
	output logic [COUNTER_BITS-1:0]      scol_n,
	output jts_pkg::token_t              tok0,
	output jts_pkg::token_t              tok1,
	output logic [1:0]                   push_cnt
);
	import jts_pkg::*;

	localparam int CB = COUNTER_BITS;

	function automatic logic [CB-1:0] sat_inc(input logic [CB-1:0] v);
		return (v == {CB{1'b1}}) ? v : v + 1'b1;
	endfunction

	function automatic logic [31:0] clamp32(input logic [CB-1:0] v);
		logic [CB+31:0] ext;
		logic [CB+31:0] lim;
		begin
			ext = (CB + 32)'(v);
			lim = (CB + 32)'(32'hFFFF_FFFF);
			return (ext > lim) ? 32'hFFFF_FFFF : ext[31:0];
		end
	endfunction

	function automatic token_t mk_tok(input tok_kind_t k, input logic [CB-1:0] ln,
			input logic [CB-1:0] cl, input logic [CB-1:0] off, input logic [CB-1:0] len);
		token_t t;
		begin
			t.kind   = k;
			t.line   = clamp32(ln);
			t.column = clamp32(cl);
			t.offset = clamp32(off);
			t.length = clamp32(len);
			t.last   = 1'b0;
			return t;
		end
	endfunction

	logic [CB-1:0] pos_c, line_c, col_c;
	logic [CB-1:0] zero_c;
	logic          is_dig, is_alp, is_nl;
	logic          pre_v, post_v, cont;
	token_t        pre_t, post_t;
	mode_t         nx;

	assign zero_c = '0;
	assign is_nl  = (text_byte == CH_LF);
	assign is_dig = (text_byte >= CH_0) && (text_byte <= CH_9);
	assign is_alp = ((text_byte >= CH_LO_A) && (text_byte <= CH_LO_Z)) ||
			((text_byte >= CH_UP_A) && (text_byte <= CH_UP_Z));

	// Counters after this byte is consumed.
	assign pos_c  = sat_inc(pos_q);
	assign line_c = is_nl ? sat_inc(line_q) : line_q;
	assign col_c  = is_nl ? CB'(1) : sat_inc(col_q);

	always_comb begin
		mode_n  = mode_q;
		kw_n    = kw_q;
		pos_n   = pos_q;
		line_n  = line_q;
		col_n   = col_q;
		soff_n  = soff_q;
		sline_n = sline_q;
		scol_n  = scol_q;
		pre_v   = 1'b0;
		post_v  = 1'b0;
		pre_t   = '0;
		post_t  = '0;
		cont    = 1'b0;
		nx      = M_IDLE;

		// Finish or extend the token in progress.
		case (mode_q)
			M_STR, M_ESC: begin
				if (fin) begin
					pre_v = 1'b1;
					pre_t = mk_tok(TK_INVALID, line_q, col_q, zero_c, zero_c);
					cont  = 1'b1;
				end else begin
					if (mode_q == M_ESC) begin
						mode_n = M_STR;
					end else if (text_byte == CH_QUOTE) begin
						pre_v  = 1'b1;
						pre_t  = mk_tok(TK_STRING, sline_q, scol_q, soff_q, pos_q - soff_q);
						mode_n = M_IDLE;
					end else if (text_byte == CH_BSLASH) begin
						mode_n = M_ESC;
					end
					pos_n  = pos_c;
					line_n = line_c;
					col_n  = col_c;
				end
			end
			M_INT, M_FRAC, M_EXP0, M_EXPD: begin
				if (!fin) begin
					case (mode_q)
						M_INT: begin
							if (is_dig) nx = M_INT;
							else if (text_byte == CH_DOT) nx = M_FRAC;
							else if (text_byte == CH_LO_E || text_byte == CH_UP_E) nx = M_EXP0;
						end
						M_FRAC: begin
							if (is_dig) nx = M_FRAC;
							else if (text_byte == CH_LO_E || text_byte == CH_UP_E) nx = M_EXP0;
						end
						M_EXP0: begin
							if (is_dig || text_byte == CH_PLUS || text_byte == CH_MINUS)
								nx = M_EXPD;
						end
						default: begin
							if (is_dig) nx = M_EXPD;
						end
					endcase
				end
				if (nx != M_IDLE) begin
					mode_n = nx;
					pos_n  = pos_c;
					line_n = line_c;
					col_n  = col_c;
				end else begin
					pre_v  = 1'b1;
					pre_t  = mk_tok(TK_NUMBER, sline_q, scol_q, soff_q, pos_q - soff_q);
					mode_n = M_IDLE;
					cont   = 1'b1;
				end
			end
			M_WORD: begin
				if (!fin && is_alp) begin
					kw_n   = kw_next(kw_q, text_byte);
					pos_n  = pos_c;
					line_n = line_c;
					col_n  = col_c;
				end else begin
					pre_v = 1'b1;
					if (kw_q == KW_TRUE)
						pre_t = mk_tok(TK_TRUE, sline_q, scol_q, zero_c, zero_c);
					else if (kw_q == KW_FALSE)
						pre_t = mk_tok(TK_FALSE, sline_q, scol_q, zero_c, zero_c);
					else if (kw_q == KW_NULL)
						pre_t = mk_tok(TK_NULL, sline_q, scol_q, zero_c, zero_c);
					else
						pre_t = mk_tok(TK_INVALID, line_q, col_q, zero_c, zero_c);
					mode_n = M_IDLE;
					kw_n   = KW_NONE;
					cont   = 1'b1;
				end
			end
			default: begin
				cont = 1'b1;
			end
		endcase

		// The byte starts a new token, or the document ends here.
		if (cont) begin
			if (fin) begin
				post_v  = 1'b1;
				post_t  = mk_tok(TK_EOF, line_q, col_q, zero_c, zero_c);
				mode_n  = M_IDLE;
				kw_n    = KW_NONE;
				pos_n   = '0;
				line_n  = CB'(1);
				col_n   = CB'(1);
				soff_n  = '0;
				sline_n = '0;
				scol_n  = '0;
			end else begin
				pos_n  = pos_c;
				line_n = line_c;
				col_n  = col_c;
				case (text_byte)
					CH_SPACE, CH_TAB, CH_CR, CH_LF: begin
					end
					CH_LBRACE: begin
						post_v = 1'b1;
						post_t = mk_tok(TK_LBRACE, line_c, col_c, zero_c, zero_c);
					end
					CH_RBRACE: begin
						post_v = 1'b1;
						post_t = mk_tok(TK_RBRACE, line_c, col_c, zero_c, zero_c);
					end
					CH_LBRACK: begin
						post_v = 1'b1;
						post_t = mk_tok(TK_LBRACK, line_c, col_c, zero_c, zero_c);
					end
					CH_RBRACK: begin
						post_v = 1'b1;
						post_t = mk_tok(TK_RBRACK, line_c, col_c, zero_c, zero_c);
					end
					CH_COMMA: begin
						post_v = 1'b1;
						post_t = mk_tok(TK_COMMA, line_c, col_c, zero_c, zero_c);
					end
					CH_COLON: begin
						post_v = 1'b1;
						post_t = mk_tok(TK_COLON, line_c, col_c, zero_c, zero_c);
					end
					CH_QUOTE: begin
						// String text starts after the opening quote.
						soff_n  = pos_c;
						sline_n = line_c;
						scol_n  = col_c;
						mode_n  = M_STR;
					end
					default: begin
						if (is_dig || text_byte == CH_MINUS) begin
							soff_n  = pos_q;
							sline_n = line_q;
							scol_n  = col_q;
							mode_n  = M_INT;
						end else if (is_alp) begin
							soff_n  = pos_q;
							sline_n = line_q;
							scol_n  = col_q;
							mode_n  = M_WORD;
							if (text_byte == CH_LO_T)      kw_n = KW_T;
							else if (text_byte == CH_LO_F) kw_n = KW_F;
							else if (text_byte == CH_LO_N) kw_n = KW_N;
							else                           kw_n = KW_FAIL;
						end else begin
							post_v = 1'b1;
							post_t = mk_tok(TK_INVALID, line_c, col_c, zero_c, zero_c);
						end
					end
				endcase
			end
		end
	end

	always_comb begin
		push_cnt  = 2'(pre_v) + 2'(post_v);
		tok0      = pre_v ? pre_t : post_t;
		tok0.last = (push_cnt == 2'd1);
		tok1      = post_t;
		tok1.last = 1'b1;
	end

endmodule
`default_nettype wire

/* sv/json_token_scanner_unit.sv */
// Streaming JSON scanner: one text byte in per item, tokens out.
//
// Input channel (s_*): one source byte per item in s_tdata; s_tlast marks end
// of document, and a zero byte does the same. Output channel (m_*): one token
// per item with kind, line, column, text offset and text length in m_tdata;
// m_tlast is set on the final token caused by an input byte.
//
// An accepted byte is held in the input register while the scanner logic
// updates its counters and writes zero, one or two tokens into an
// eight-entry result queue, whose head drives m_tvalid. A byte is accepted
// every cycle while s_tready is high; one that ends a token and starts
// another (or ends the document) makes two tokens, which leave one after
// the other, so the output side sets the pace at one token per cycle while
// m_tready is high. s_tready drops when the queue could not take the tokens
// of the byte in the input register plus the next one.
//
// Reset clears the queue and returns the scanner to the start of a document
// (line 1, column 1, offset 0). A stalled receiver just fills the queue and
// then holds s_tready low; nothing is lost or repeated. End of document
// flushes the pending token, emits an eof token and starts a new document.
`default_nettype none
module json_token_scanner_unit #(
	parameter int COUNTER_BITS = 32
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	input  wire logic [jts_pkg::IN_TDATA_W-1:0]     s_tdata,   // [7:0] text_byte
	input  wire logic                               s_tlast,   // end_of_input
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	// [3:0] token_kind, [35:4] token_line, [67:36] token_column,
	// [99:68] span_offset, [131:100] span_length, [135:132] zero
	output logic [jts_pkg::OUT_TDATA_W-1:0]         m_tdata,
	output logic                                    m_tlast    // last_of_run
);
	import jts_pkg::*;

	localparam int CB = COUNTER_BITS;

	logic                  valid_s1;
	logic [7:0]            byte_s1;
	logic                  eoi_s1;
	logic                  fin_s1;

	mode_t                 mode_q, mode_n;
	logic [3:0]            kw_q, kw_n;
	logic [CB-1:0]         pos_q, pos_n;
	logic [CB-1:0]         line_q, line_n;
	logic [CB-1:0]         col_q, col_n;
	logic [CB-1:0]         soff_q, soff_n;
	logic [CB-1:0]         sline_q, sline_n;
	logic [CB-1:0]         scol_q, scol_n;

	token_t                tok0, tok1, head;
	logic [1:0]            lex_cnt, push_cnt;
	logic [FIFO_CNT_W-1:0] count;
	logic [FIFO_CNT_W-1:0] inflight;
	logic                  pop;

	assign inflight = valid_s1 ? FIFO_CNT_W'(2) : FIFO_CNT_W'(0);
	assign s_tready = (count + inflight) <= ACCEPT_LIMIT + FIFO_CNT_W'(2);
	assign fin_s1   = eoi_s1 || (byte_s1 == CH_NUL);
	assign push_cnt = valid_s1 ? lex_cnt : 2'd0;
	assign m_tvalid = (count != '0);
	assign pop      = m_tvalid && m_tready;
	assign m_tdata  = {4'b0, head.length, head.offset, head.column, head.line, head.kind};
	assign m_tlast  = head.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else         valid_s1 <= s_tvalid && s_tready;
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			eoi_s1  <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			kw_q    <= KW_NONE;
			pos_q   <= '0;
			line_q  <= CB'(1);
			col_q   <= CB'(1);
			soff_q  <= '0;
			sline_q <= '0;
			scol_q  <= '0;
		end else if (valid_s1) begin
			mode_q  <= mode_n;
			kw_q    <= kw_n;
			pos_q   <= pos_n;
			line_q  <= line_n;
			col_q   <= col_n;
			soff_q  <= soff_n;
			sline_q <= sline_n;
			scol_q  <= scol_n;
		end
	end

	jts_lexer #(
		.COUNTER_BITS(COUNTER_BITS)
	) u_lexer (
		.text_byte (byte_s1),
		.fin       (fin_s1),
		.mode_q    (mode_q),
		.kw_q      (kw_q),
		.pos_q     (pos_q),
		.line_q    (line_q),
		.col_q     (col_q),
		.soff_q    (soff_q),
		.sline_q   (sline_q),
		.scol_q    (scol_q),
		.mode_n    (mode_n),
		.kw_n      (kw_n),
		.pos_n     (pos_n),
		.line_n    (line_n),
		.col_n     (col_n),
		.soff_n    (soff_n),
		.sline_n   (sline_n),
		.scol_n    (scol_n),
		.tok0      (tok0),
		.tok1      (tok1),
		.push_cnt  (lex_cnt)
	);

	jts_token_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_cnt (push_cnt),
		.push0    (tok0),
		.push1    (tok1),
		.pop      (pop),
		.head     (head),
		.count    (count)
	);

`ifndef NO_ASSERTIONS
	// The result queue never overflows.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(FIFO_CNT_W + 1)'(count) + (FIFO_CNT_W + 1)'(push_cnt) <= (FIFO_CNT_W + 1)'(FIFO_DEPTH))
		else $error("result queue overflow");

	// End of document always yields at least the eof token.
	a_fin_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && fin_s1) |-> (push_cnt != 2'd0))
		else $error("end of document produced no token");

	// After end of document the scanner is back at the start of a document.
	a_fin_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && fin_s1) |=> (mode_q == M_IDLE && pos_q == '0 && line_q == CB'(1)
			&& col_q == CB'(1)))
		else $error("scanner state not cleared after end of document");

	// Two tokens from one byte: only the second one closes the run.
	a_last_order: assert property (@(posedge clk) disable iff (!arst_n)
		(push_cnt == 2'd2) |-> (!tok0.last && tok1.last))
		else $error("last_of_run misplaced on a two-token byte");
`endif

endmodule
`default_nettype wire

/* sim/tb_json_token_scanner_unit.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the JSON token scanner: random documents in, predicted tokens out.
module tb_json_token_scanner_unit;
	import jts_pkg::*;

	localparam int STALL_LIMIT = 5000;
	localparam int HOLD_CYCLES = 400;

	typedef struct {
		tok_kind_t   kind;
		logic [31:0] line;
		logic [31:0] column;
		logic [31:0] offset;
		logic [31:0] length;
		logic        last;
	} exp_token_t;

	// Predicts the token stream of the scanner and compares it with what comes out.
	class token_scoreboard;
		mode_t       mode;
		logic [3:0]  kw_code;
		logic [31:0] byte_pos;
		logic [31:0] line_no;
		logic [31:0] col_no;
		logic [31:0] tok_offset;
		logic [31:0] tok_line;
		logic [31:0] tok_col;
		exp_token_t  token_q[$];
		int          errors;
		int          checked;
		int          documents;

		function new();
			errors = 0;
			checked = 0;
			documents = 0;
			restart_document();
		endfunction

		function void restart_document();
			mode = M_IDLE;
			kw_code = KW_NONE;
			byte_pos = 32'd0;
			line_no = 32'd1;
			col_no = 32'd1;
			tok_offset = 32'd0;
			tok_line = 32'd0;
			tok_col = 32'd0;
		endfunction

		function logic [31:0] sat_inc(logic [31:0] v);
			return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
		endfunction

		function void advance_position(logic [7:0] b);
			byte_pos = sat_inc(byte_pos);
			if (b == CH_LF) begin
				line_no = sat_inc(line_no);
				col_no = 32'd1;
			end else begin
				col_no = sat_inc(col_no);
			end
		endfunction

		function void mark_token_start();
			tok_line = line_no;
			tok_col = col_no;
			tok_offset = byte_pos;
		endfunction

		function void push_token(tok_kind_t k, logic [31:0] ln, logic [31:0] cl,
				logic [31:0] off, logic [31:0] len);
			exp_token_t t;
			t.kind = k;
			t.line = ln;
			t.column = cl;
			t.offset = off;
			t.length = len;
			t.last = 1'b0;
			token_q.push_back(t);
		endfunction

		// Follows one more letter of a word against the three keywords.
		function logic [3:0] keyword_step(logic [3:0] code, logic [7:0] b);
			string w;
			logic [3:0] base;
			int len;
			if (code >= KW_T && code <= KW_TRUE) begin
				w = "true";
				base = KW_T;
			end else if (code >= KW_F && code <= KW_FALSE) begin
				w = "false";
				base = KW_F;
			end else if (code >= KW_N && code <= KW_NULL) begin
				w = "null";
				base = KW_N;
			end else begin
				return KW_FAIL;
			end
			len = int'(code - base) + 1;
			if (len < w.len() && b == w[len])
				return code + 4'd1;
			return KW_FAIL;
		endfunction

		function bit is_digit(logic [7:0] b);
			return b >= CH_0 && b <= CH_9;
		endfunction

		function bit is_letter(logic [7:0] b);
			return (b >= CH_LO_A && b <= CH_LO_Z) || (b >= CH_UP_A && b <= CH_UP_Z);
		endfunction

		function void note_byte(logic [7:0] b, logic eoi);
			bit    fin;
			bit    absorbed;
			int    queued_at_entry;
			mode_t nx;
			fin = eoi || b == CH_NUL;
			absorbed = 0;
			queued_at_entry = token_q.size();
			if (mode == M_STR || mode == M_ESC) begin
				if (fin) begin
					push_token(TK_INVALID, line_no, col_no, 32'd0, 32'd0);
				end else begin
					if (mode == M_ESC) begin
						mode = M_STR;
					end else if (b == CH_QUOTE) begin
						push_token(TK_STRING, tok_line, tok_col, tok_offset,
							byte_pos - tok_offset);
						mode = M_IDLE;
					end else if (b == CH_BSLASH) begin
						mode = M_ESC;
					end
					advance_position(b);
					absorbed = 1;
				end
			end else if (mode >= M_INT && mode <= M_EXPD) begin
				nx = M_IDLE;
				if (!fin) begin
					case (mode)
						M_INT: begin
							if (is_digit(b)) nx = M_INT;
							else if (b == CH_DOT) nx = M_FRAC;
							else if (b == CH_LO_E || b == CH_UP_E) nx = M_EXP0;
						end
						M_FRAC: begin
							if (is_digit(b)) nx = M_FRAC;
							else if (b == CH_LO_E || b == CH_UP_E) nx = M_EXP0;
						end
						M_EXP0: begin
							if (is_digit(b) || b == CH_PLUS || b == CH_MINUS) nx = M_EXPD;
						end
						default: begin
							if (is_digit(b)) nx = M_EXPD;
						end
					endcase
				end
				if (nx != M_IDLE) begin
					mode = nx;
					advance_position(b);
					absorbed = 1;
				end else begin
					push_token(TK_NUMBER, tok_line, tok_col, tok_offset, byte_pos - tok_offset);
					mode = M_IDLE;
				end
			end else if (mode == M_WORD) begin
				if (!fin && is_letter(b)) begin
					kw_code = keyword_step(kw_code, b);
					advance_position(b);
					absorbed = 1;
				end else begin
					if (kw_code == KW_TRUE)
						push_token(TK_TRUE, tok_line, tok_col, 32'd0, 32'd0);
					else if (kw_code == KW_FALSE)
						push_token(TK_FALSE, tok_line, tok_col, 32'd0, 32'd0);
					else if (kw_code == KW_NULL)
						push_token(TK_NULL, tok_line, tok_col, 32'd0, 32'd0);
					else
						push_token(TK_INVALID, line_no, col_no, 32'd0, 32'd0);
					mode = M_IDLE;
					kw_code = KW_NONE;
				end
			end

			// A byte not taken by a token in progress starts the next token here, or ends the document.
			if (!absorbed) begin
				if (fin) begin
					push_token(TK_EOF, line_no, col_no, 32'd0, 32'd0);
					restart_document();
					documents++;
				end else begin
					case (b)
						CH_SPACE, CH_TAB, CH_CR, CH_LF: advance_position(b);
						CH_LBRACE, CH_RBRACE, CH_LBRACK, CH_RBRACK, CH_COMMA, CH_COLON: begin
							advance_position(b);
							case (b)
								CH_LBRACE: push_token(TK_LBRACE, line_no, col_no, 32'd0, 32'd0);
								CH_RBRACE: push_token(TK_RBRACE, line_no, col_no, 32'd0, 32'd0);
								CH_LBRACK: push_token(TK_LBRACK, line_no, col_no, 32'd0, 32'd0);
								CH_RBRACK: push_token(TK_RBRACK, line_no, col_no, 32'd0, 32'd0);
								CH_COMMA:  push_token(TK_COMMA, line_no, col_no, 32'd0, 32'd0);
								default:   push_token(TK_COLON, line_no, col_no, 32'd0, 32'd0);
							endcase
						end
						CH_QUOTE: begin
							// A string is reported from just after its opening quote.
							advance_position(b);
							mark_token_start();
							mode = M_STR;
						end
						default: begin
							if (is_digit(b) || b == CH_MINUS) begin
								mark_token_start();
								advance_position(b);
								mode = M_INT;
							end else if (is_letter(b)) begin
								mark_token_start();
								advance_position(b);
								mode = M_WORD;
								kw_code = (b == CH_LO_T) ? KW_T : (b == CH_LO_F) ? KW_F :
									(b == CH_LO_N) ? KW_N : KW_FAIL;
							end else begin
								advance_position(b);
								push_token(TK_INVALID, line_no, col_no, 32'd0, 32'd0);
							end
						end
					endcase
				end
			end
			if (token_q.size() > queued_at_entry)
				token_q[token_q.size() - 1].last = 1'b1;
		endfunction

		task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
			$display("mismatch at token %0d: %s is %0h, expected %0h", checked, what, got,
				want);
			errors++;
		endtask

		task check_token(logic [135:0] d, logic last);
			exp_token_t t;
			if (token_q.size() == 0) begin
				report_mismatch("unexpected token, kind", 32'(d[3:0]), 32'd0);
				return;
			end
			t = token_q.pop_front();
			if (d[3:0] != t.kind)     report_mismatch("kind", 32'(d[3:0]), 32'(t.kind));
			if (d[35:4] != t.line)    report_mismatch("line", d[35:4], t.line);
			if (d[67:36] != t.column) report_mismatch("column", d[67:36], t.column);
			if (d[99:68] != t.offset) report_mismatch("offset", d[99:68], t.offset);
			if (d[131:100] != t.length) report_mismatch("length", d[131:100], t.length);
			if (last != t.last)       report_mismatch("last flag", 32'(last), 32'(t.last));
			checked++;
		endtask

		function int pending();
			return token_q.size();
		endfunction
	endclass

	logic         clk = 1'b0;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [7:0]   s_tdata;
	logic         s_tlast;
	logic         m_tvalid;
	logic         m_tready;
	logic [135:0] m_tdata;
	logic         m_tlast;

	token_scoreboard sb;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int items_sent = 0;
	int hold_req_cnt = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int idle_cycles = 0;
	string keywords[3] = '{"true", "false", "null"};

	json_token_scanner_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver: random backpressure, plus a long hold whenever one is requested.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_token(m_tdata, m_tlast);
			if (hold_seen != hold_req_cnt) begin
				hold_seen <= hold_req_cnt;
				hold_left <= HOLD_CYCLES;
				m_tready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("no item moved for %0d cycles", STALL_LIMIT);
			$display("TB_ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_item(input logic [7:0] b, input logic eoi);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= eoi;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_byte(b, eoi);
		items_sent++;
	endtask

	task automatic send_text(input string t);
		for (int i = 0; i < t.len(); i++)
			send_item(t[i], 1'b0);
	endtask

	function automatic logic [7:0] rand_letter();
		return ($urandom_range(1) != 0) ? CH_LO_A + 8'($urandom_range(25)) :
			CH_UP_A + 8'($urandom_range(25));
	endfunction

	function automatic logic [7:0] rand_digit();
		return CH_0 + 8'($urandom_range(9));
	endfunction

	task automatic send_string_body();
		int len;
		logic [7:0] c;
		len = $urandom_range(6);
		repeat (len) begin
			case ($urandom_range(9))
				0: begin
					send_item(CH_BSLASH, 1'b0);
					send_item(8'($urandom_range(255, 1)), 1'b0);
				end
				1: send_item(CH_LF, 1'b0);
				default: begin
					c = 8'($urandom_range(126, 32));
					send_item((c == CH_QUOTE || c == CH_BSLASH) ? CH_LO_A : c, 1'b0);
				end
			endcase
		end
	endtask

	task automatic send_number();
		if ($urandom_range(1) != 0) send_item(CH_MINUS, 1'b0);
		repeat ($urandom_range(4, 1)) send_item(rand_digit(), 1'b0);
		if ($urandom_range(9) < 4) begin
			send_item(CH_DOT, 1'b0);
			repeat ($urandom_range(3, 1)) send_item(rand_digit(), 1'b0);
		end
		if ($urandom_range(9) < 3) begin
			send_item(($urandom_range(1) != 0) ? CH_LO_E : CH_UP_E, 1'b0);
			case ($urandom_range(2))
				0: send_item(CH_PLUS, 1'b0);
				1: send_item(CH_MINUS, 1'b0);
				default: ;
			endcase
			repeat ($urandom_range(2, 1)) send_item(rand_digit(), 1'b0);
		end
	endtask

	task automatic send_word();
		string w;
		int k;
		k = $urandom_range(5);
		if (k < 3) begin
			send_text(keywords[k]);
		end else if (k == 3) begin
			// A keyword prefix, at times the whole keyword, sometimes with a letter too many.
			w = keywords[$urandom_range(2)];
			send_text(w.substr(0, $urandom_range(w.len() - 1)));
			if ($urandom_range(1) != 0) send_item(rand_letter(), 1'b0);
		end else begin
			repeat ($urandom_range(6, 1)) send_item(rand_letter(), 1'b0);
		end
	endtask

	task automatic send_lexeme();
		int pick;
		string punct;
		string blank;
		string numch;
		punct = "{}[],:";
		blank = " \t\r\n";
		numch = "0123456789+-.eE";
		pick = $urandom_range(99);
		if (pick < 15) begin
			send_item(punct[$urandom_range(5)], 1'b0);
		end else if (pick < 30) begin
			send_item(blank[$urandom_range(3)], 1'b0);
		end else if (pick < 48) begin
			send_item(CH_QUOTE, 1'b0);
			send_string_body();
			send_item(CH_QUOTE, 1'b0);
		end else if (pick < 66) begin
			send_number();
		end else if (pick < 84) begin
			send_word();
		end else if (pick < 92) begin
			// Broken number text.
			repeat ($urandom_range(5, 1)) send_item(numch[$urandom_range(14)], 1'b0);
		end else begin
			send_item(8'($urandom_range(255, 1)), 1'b0);
		end
	endtask

	task automatic send_document();
		repeat ($urandom_range(12, 1)) send_lexeme();
		case ($urandom_range(9))
			6, 7: send_item(CH_NUL, 1'b0);
			8: begin
				send_item(CH_QUOTE, 1'b0);
				send_string_body();
				if ($urandom_range(1) != 0) send_item(CH_BSLASH, 1'b0);
				send_item(8'($urandom_range(255)), 1'b1);
			end
			default: send_item(8'($urandom_range(255)), 1'b1);
		endcase
	endtask

	task automatic send_until(input int target);
		while (items_sent < target)
			send_document();
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = 8'd0;
		s_tlast = 1'b0;
		m_tready = 1'b0;
		sb = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 35;
		recv_idle_pct = 63;
		// Lone minus ended by a zero byte.
		send_text("-");
		send_item(CH_NUL, 1'b0);
		// Escaped quote in a string, exponent number cut by a bracket, null, a bad word.
		send_text("{\"\\\"\":1.5E+9]null,x");
		send_item(8'hFF, 1'b0);
		// End of input inside a string right after a backslash, then on an empty document.
		send_text("\n\"\\");
		send_item(8'hA5, 1'b1);
		send_item(8'h00, 1'b1);
		send_until(420);

		send_idle_pct = 63;
		recv_idle_pct = 35;
		send_until(820);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_req_cnt++;
		send_until(1220);
		s_tvalid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Sent %0d bytes over %0d documents; %0d tokens checked, %0d mismatches.",
			items_sent, sb.documents, sb.checked, sb.errors);
		$display("Included escapes, numbers, keywords, bad bytes and a long output hold.");
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
